// ===== hdl/nupf_pkg.sv =====
// Package for the NAL unit packet fragmenter.
// Holds the register indexes, reset values and framing constants.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package nupf_pkg;

   localparam int unsigned HDR_BYTES = 4;
   localparam int unsigned MAX_RESULTS = HDR_BYTES + 1;
   localparam int unsigned LIMIT_W = 11;
   localparam int unsigned MASK_W = 32;
   localparam int unsigned TYPE_W = 5;
   localparam int unsigned POS_W = 3;
   localparam int unsigned CNT_W = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_MAX = 11'd1496;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd508;
   localparam logic [MASK_W-1:0] MASK_RESET = 32'd416;
   localparam logic [TYPE_W-1:0] TYPE_MASK = 5'h1F;

   typedef enum logic [0:0] {
      REG_PAYLOAD_LIMIT = 1'b0,
      REG_ACCEPT_MASK = 1'b1
   } reg_index_type;

endpackage

`default_nettype wire

// ===== hdl/nal_unit_packet_fragmenter_unit.sv =====
// Top level of the NAL unit packet fragmenter.
// Depends on nupf_pkg for constants and the register index codes.
//
// Takes one byte of a start-code-prefixed H.264 NAL unit per transfer and emits a packet
// stream: each packet is a 4-byte header (frame number low, frame number high, fragment
// index, NAL type) and up to payload_limit payload bytes, with the last byte marked.
// A payload byte that does not open a packet is held alone, so bytes stream at
// one per cycle while the output is not stalled. A byte that opens a packet yields five
// output bytes, and the five-entry output holding register then keeps the input stalled
// until only the last of them is held. The start code and rejected units produce no
// output and are taken at one byte per cycle while no earlier output is held.
// Configuration writes are always taken and should be made while the block is idle.
`default_nettype none

module nal_unit_packet_fragmenter_unit
   import nupf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_end_of_packet,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [0:0]           csr_index,
   input  wire logic [MASK_W-1:0]    csr_data
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LIMIT_W-1:0] count_ff, count_in;
   logic [7:0]         frag_ff, frag_in;
   logic [15:0]        frame_ff, frame_in;
   logic               acc_ff, acc_in;
   logic [TYPE_W-1:0]  type_ff, type_in;

   logic [7:0]         hold_byte_ff [MAX_RESULTS];
   logic               hold_eop_ff [MAX_RESULTS];
   logic [CNT_W-1:0]   hold_cnt_ff;

   logic               req_xfer, rsp_xfer;
   logic [LIMIT_W-1:0] lim;
   logic [LIMIT_W-1:0] count_mid;
   logic [7:0]         frag_hdr;
   logic               first, hdr_needed, emit, eop;

   assign csr_ready = 1'b1;
   assign rsp_valid = (hold_cnt_ff != '0);
   assign rsp_out_byte = hold_byte_ff[0];
   assign rsp_end_of_packet = hold_eop_ff[0];
   assign req_ready = (hold_cnt_ff == '0) || ((hold_cnt_ff == CNT_W'(1)) && rsp_ready);
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      if (limit_ff == '0) begin
         lim = LIMIT_W'(1);
      end else if (limit_ff > LIMIT_MAX) begin
         lim = LIMIT_MAX;
      end else begin
         lim = limit_ff;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      count_in = count_ff;
      frag_in = frag_ff;
      frame_in = frame_ff;
      acc_in = acc_ff;
      type_in = type_ff;
      count_mid = count_ff;
      first = 1'b0;
      hdr_needed = 1'b0;
      emit = 1'b0;
      eop = 1'b0;
      if (pos_ff < POS_W'(HDR_BYTES)) begin
         pos_in = pos_ff + POS_W'(1);
      end else begin
         if (pos_ff == POS_W'(HDR_BYTES)) begin
            type_in = req_data_byte[TYPE_W-1:0] & TYPE_MASK;
            acc_in = mask_ff[type_in];
            if (acc_in) begin
               frame_in = frame_ff + 16'd1;
               frag_in = '0;
               count_mid = '0;
               first = 1'b1;
            end
            pos_in = POS_W'(HDR_BYTES + 1);
         end
         if (acc_in) begin
            emit = 1'b1;
            hdr_needed = first || (count_mid >= lim);
            if (hdr_needed && !first) begin
               frag_in = frag_ff + 8'd1;
               count_mid = '0;
            end
            count_in = count_mid + LIMIT_W'(1);
            eop = req_last_byte || (count_in >= lim);
         end
      end
      frag_hdr = frag_in;
      if (req_last_byte) begin
         pos_in = '0;
         count_in = '0;
         frag_in = '0;
         acc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         mask_ff <= MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_PAYLOAD_LIMIT: limit_ff <= csr_data[LIMIT_W-1:0];
            REG_ACCEPT_MASK: mask_ff <= csr_data;
            default: limit_ff <= limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         count_ff <= '0;
         frag_ff <= '0;
         frame_ff <= '0;
         acc_ff <= 1'b0;
         type_ff <= '0;
      end else if (req_xfer) begin
         pos_ff <= pos_in;
         count_ff <= count_in;
         frag_ff <= frag_in;
         frame_ff <= frame_in;
         acc_ff <= acc_in;
         type_ff <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_cnt_ff <= '0;
      end else if (req_xfer && emit) begin
         hold_cnt_ff <= hdr_needed ? CNT_W'(MAX_RESULTS) : CNT_W'(1);
      end else if (rsp_xfer) begin
         hold_cnt_ff <= hold_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && emit) begin
         if (hdr_needed) begin
            hold_byte_ff[0] <= frame_in[7:0];
            hold_byte_ff[1] <= frame_in[15:8];
            hold_byte_ff[2] <= frag_hdr;
            hold_byte_ff[3] <= {{(8-TYPE_W){1'b0}}, type_in};
            hold_byte_ff[4] <= req_data_byte;
            hold_eop_ff[0] <= 1'b0;
            hold_eop_ff[1] <= 1'b0;
            hold_eop_ff[2] <= 1'b0;
            hold_eop_ff[3] <= 1'b0;
            hold_eop_ff[4] <= eop;
         end else begin
            hold_byte_ff[0] <= req_data_byte;
            hold_eop_ff[0] <= eop;
         end
      end else if (rsp_xfer) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            hold_byte_ff[i] <= hold_byte_ff[i+1];
            hold_eop_ff[i] <= hold_eop_ff[i+1];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/nupf_checker.sv =====
// Port-level checker for the NAL unit packet fragmenter, bound to the top level.
// Depends on nupf_pkg for the field widths.
`default_nettype none

module nupf_checker
   import nupf_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [7:0]        req_data_byte,
   input wire logic              req_last_byte,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [7:0]        rsp_out_byte,
   input wire logic              rsp_end_of_packet,
   input wire logic              csr_valid,
   input wire logic              csr_ready,
   input wire logic [0:0]        csr_index,
   input wire logic [MASK_W-1:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_end_of_packet))
      else $error("Stalled result transfer changed.");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("Input taken while a result was stuck.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result shown right after reset.");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("Configuration write was refused.");

endmodule

bind nal_unit_packet_fragmenter_unit nupf_checker u_nupf_checker (.*);

`default_nettype wire
